/* hdl/isog_pkg.sv */
// Package for the interpolation seek offset guess unit.
// Holds field widths, ratio and rollback constants, result codes and the
// command and status structs shared by the controller and the datapath.
package isog_pkg;

  localparam int UNIT_W = 47;
  localparam int OFF_W  = 48;
  localparam int FRAC_W = 16;
  localparam int Q_W    = UNIT_W + FRAC_W;
  localparam int PROD_W = OFF_W + Q_W;
  localparam int CNT_W  = $clog2(Q_W);

  localparam longint GUESS_ONE = longint'(1) << FRAC_W;

  localparam logic [Q_W-1:0] R_LOW   = Q_W'(GUESS_ONE / 5);
  localparam logic [Q_W-1:0] R_HIGH  = Q_W'(4 * GUESS_ONE / 5);
  localparam logic [Q_W-1:0] R_ZLOW  = Q_W'(2 * GUESS_ONE / 5);
  localparam logic [Q_W-1:0] R_ZHIGH = Q_W'(3 * GUESS_ONE / 5);

  localparam logic [OFF_W-1:0] ROLLBACK = OFF_W'(4 * 2048);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(Q_W - 1);

  localparam logic [1:0] OUTC_INTERP = 2'd0;
  localparam logic [1:0] OUTC_ZOOM   = 2'd1;
  localparam logic [1:0] OUTC_NOPROG = 2'd2;
  localparam logic [1:0] OUTC_ZERO   = 2'd3;

  localparam logic [1:0] PLACE_END  = 2'd0;
  localparam logic [1:0] PLACE_ROLL = 2'd1;
  localparam logic [1:0] PLACE_SNAP = 2'd2;

  typedef struct packed {
    logic load;
    logic div_step;
    logic zoom;
    logic mul_step;
    logic guess;
    logic emit;
    logic emit_special;
  } isog_cmd_t;

  typedef struct packed {
    logic den_zero;
  } isog_sts_t;

endpackage

/* hdl/isog_ctrl.sv */
// Controller of the interpolation seek offset guess unit.
// Sequences loading, the serial divide, zoom, serial multiply and result
// write-out. Depends on isog_pkg.
module isog_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  isog_pkg::isog_sts_t sts_i,
  output isog_pkg::isog_cmd_t cmd_o
);
  import isog_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ZOOM,
    ST_MUL,
    ST_GUESS,
    ST_EMIT,
    ST_SPECIAL
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o              = '0;
    cmd_o.load         = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.div_step     = (state_q == ST_DIV);
    cmd_o.zoom         = (state_q == ST_ZOOM);
    cmd_o.mul_step     = (state_q == ST_MUL);
    cmd_o.guess        = (state_q == ST_GUESS);
    cmd_o.emit         = (state_q == ST_EMIT) && slot_free;
    cmd_o.emit_special = (state_q == ST_SPECIAL) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit || cmd_o.emit_special) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          cnt_q   <= '0;
          state_q <= sts_i.den_zero ? ST_SPECIAL : ST_DIV;
        end
        ST_DIV: begin
          if (cnt_q == LAST_STEP) begin
            cnt_q   <= '0;
            state_q <= ST_ZOOM;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_ZOOM: begin
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (cnt_q == LAST_STEP) begin
            cnt_q   <= '0;
            state_q <= ST_GUESS;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_GUESS: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT, ST_SPECIAL: begin
          if (slot_free) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/isog_dp.sv */
// Datapath of the interpolation seek offset guess unit.
// Holds the operands, a restoring divider, a shift-add multiplier, the zoom
// flag and the output registers. Depends on isog_pkg.
module isog_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  isog_pkg::isog_cmd_t          cmd_i,
  output isog_pkg::isog_sts_t          sts_o,
  input  logic                         new_search_i,
  input  logic                         end_known_i,
  input  logic [isog_pkg::UNIT_W-1:0]  seek_unit_i,
  input  logic [isog_pkg::UNIT_W-1:0]  lo_unit_i,
  input  logic [isog_pkg::UNIT_W-1:0]  hi_unit_i,
  input  logic [isog_pkg::UNIT_W-1:0]  unit_current_i,
  input  logic [isog_pkg::OFF_W-1:0]   lo_off_i,
  input  logic [isog_pkg::OFF_W-1:0]   hi_off_i,
  output logic [isog_pkg::OFF_W-1:0]   probe_off_o,
  output logic [1:0]                   outcome_o,
  output logic [1:0]                   placement_o
);
  import isog_pkg::*;

  logic              zoom_last_q;
  logic              end_known_q;
  logic              num_neg_q;
  logic              den_neg_q;
  logic              d_neg_q;
  logic              r_neg_q;
  logic [UNIT_W-1:0] den_q;
  logic [UNIT_W-1:0] rem_q;
  logic [Q_W-1:0]    quo_q;
  logic [OFF_W-1:0]  d_q;
  logic [OFF_W-1:0]  obeg_q;
  logic [OFF_W-1:0]  oend_q;
  logic [PROD_W-1:0] prod_q;
  logic [OFF_W-1:0]  guess_q;
  logic [1:0]        outcome_q;
  logic [OFF_W-1:0]  res_guess_q;
  logic [1:0]        res_outcome_q;
  logic [1:0]        res_place_q;

  logic [UNIT_W-1:0] den_src;
  logic [UNIT_W-1:0] num_mag;
  logic [UNIT_W-1:0] den_mag;
  logic [OFF_W-1:0]  d_mag;

  logic [UNIT_W:0]   div_t;
  logic [UNIT_W:0]   div_diff;
  logic              div_ge;

  logic              r_neg;
  logic [Q_W-1:0]    r_sel;
  logic              r_neg_sel;
  logic [1:0]        outc_sel;
  logic              zoom_last_sel;

  logic [OFF_W:0]    mul_sum;

  logic              mag_hi;
  logic [OFF_W-1:0]  mag_lo;
  logic [OFF_W:0]    pos_sum;
  logic [OFF_W-1:0]  guess_val;

  logic [OFF_W-1:0]  roll_val;
  logic              roll_ok;

  assign den_src = end_known_i ? hi_unit_i : unit_current_i;
  assign num_mag = (seek_unit_i < lo_unit_i) ? lo_unit_i - seek_unit_i
                                             : seek_unit_i - lo_unit_i;
  assign den_mag = (den_src < lo_unit_i) ? lo_unit_i - den_src
                                         : den_src - lo_unit_i;
  assign d_mag   = (hi_off_i < lo_off_i) ? lo_off_i - hi_off_i
                                         : hi_off_i - lo_off_i;

  assign div_t    = {rem_q, quo_q[Q_W-1]};
  assign div_ge   = (div_t >= {1'b0, den_q});
  assign div_diff = div_t - {1'b0, den_q};

  assign r_neg = (num_neg_q != den_neg_q) && (quo_q != '0);

  always_comb begin
    r_sel         = quo_q;
    r_neg_sel     = r_neg;
    outc_sel      = OUTC_INTERP;
    zoom_last_sel = zoom_last_q;
    if (end_known_q) begin
      if (zoom_last_q) begin
        zoom_last_sel = 1'b0;
      end else begin
        if (r_neg || quo_q < R_LOW) begin
          r_sel     = R_ZLOW;
          r_neg_sel = 1'b0;
          outc_sel  = OUTC_ZOOM;
        end else if (quo_q > R_HIGH) begin
          r_sel    = R_ZHIGH;
          outc_sel = OUTC_ZOOM;
        end
        zoom_last_sel = 1'b1;
      end
    end
  end

  assign mul_sum = {1'b0, prod_q[PROD_W-1:Q_W]} + (prod_q[0] ? {1'b0, d_q} : '0);

  assign mag_hi  = |prod_q[PROD_W-1:OFF_W+FRAC_W];
  assign mag_lo  = prod_q[OFF_W+FRAC_W-1:FRAC_W];
  assign pos_sum = {1'b0, obeg_q} + {1'b0, mag_lo};

  always_comb begin
    if (d_neg_q != r_neg_q) begin
      guess_val = (mag_hi || mag_lo > obeg_q) ? '0 : obeg_q - mag_lo;
    end else begin
      guess_val = (mag_hi || pos_sum[OFF_W]) ? '1 : pos_sum[OFF_W-1:0];
    end
  end

  assign roll_val = guess_q - ROLLBACK;
  assign roll_ok  = (guess_q >= ROLLBACK) && (roll_val > obeg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_last_q <= 1'b0;
    end else if (cmd_i.load && new_search_i) begin
      zoom_last_q <= 1'b0;
    end else if (cmd_i.zoom) begin
      zoom_last_q <= zoom_last_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      end_known_q <= end_known_i;
      num_neg_q   <= seek_unit_i < lo_unit_i;
      den_neg_q   <= den_src < lo_unit_i;
      d_neg_q     <= hi_off_i < lo_off_i;
      den_q       <= den_mag;
      d_q         <= d_mag;
      obeg_q      <= lo_off_i;
      oend_q      <= hi_off_i;
      rem_q       <= '0;
      quo_q       <= {num_mag, FRAC_W'(0)};
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? div_diff[UNIT_W-1:0] : div_t[UNIT_W-1:0];
      quo_q <= {quo_q[Q_W-2:0], div_ge};
    end
    if (cmd_i.zoom) begin
      prod_q    <= {OFF_W'(0), r_sel};
      r_neg_q   <= r_neg_sel;
      outcome_q <= outc_sel;
    end
    if (cmd_i.mul_step) begin
      prod_q <= {mul_sum, prod_q[Q_W-1:1]};
    end
    if (cmd_i.guess) begin
      guess_q <= guess_val;
    end
    if (cmd_i.emit) begin
      res_outcome_q <= outcome_q;
      if (guess_q == oend_q) begin
        res_guess_q <= guess_q;
        res_place_q <= PLACE_END;
      end else if (roll_ok) begin
        res_guess_q <= roll_val;
        res_place_q <= PLACE_ROLL;
      end else begin
        res_guess_q <= obeg_q;
        res_place_q <= PLACE_SNAP;
      end
    end
    if (cmd_i.emit_special) begin
      res_guess_q   <= obeg_q;
      res_outcome_q <= end_known_q ? OUTC_ZERO : OUTC_NOPROG;
      res_place_q   <= PLACE_SNAP;
    end
  end

  assign sts_o.den_zero = (den_q == '0);
  assign probe_off_o    = res_guess_q;
  assign outcome_o      = res_outcome_q;
  assign placement_o    = res_place_q;

endmodule

/* hdl/interpolation_seek_offset_guess_unit.sv */
// Top level of the interpolation seek offset guess unit.
// Joins the controller isog_ctrl and the datapath isog_dp. Depends on isog_pkg.
//
// One input transaction is one bisection step and yields one result transaction.
// A step runs from acceptance to result through loading, a check of the unit span,
// the ratio divider at one bit per cycle, a zoom, the shift-add multiplier at one
// bit per cycle, forming the guess and placing it in the output register once that
// is free. A zero unit span goes from the check straight to the special result.
// One step is in flight at a time; a finished result may wait in the output
// register while the next step is accepted.
module interpolation_seek_offset_guess_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         new_search_i,
  input  logic                         end_known_i,
  input  logic [isog_pkg::UNIT_W-1:0]  seek_unit_i,
  input  logic [isog_pkg::UNIT_W-1:0]  lo_unit_i,
  input  logic [isog_pkg::UNIT_W-1:0]  hi_unit_i,
  input  logic [isog_pkg::UNIT_W-1:0]  unit_current_i,
  input  logic [isog_pkg::OFF_W-1:0]   lo_off_i,
  input  logic [isog_pkg::OFF_W-1:0]   hi_off_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [isog_pkg::OFF_W-1:0]   probe_off_o,
  output logic [1:0]                   outcome_o,
  output logic [1:0]                   placement_o
);
  import isog_pkg::*;

  isog_cmd_t cmd;
  isog_sts_t sts;

  isog_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  isog_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .new_search_i   (new_search_i),
    .end_known_i    (end_known_i),
    .seek_unit_i    (seek_unit_i),
    .lo_unit_i      (lo_unit_i),
    .hi_unit_i      (hi_unit_i),
    .unit_current_i (unit_current_i),
    .lo_off_i       (lo_off_i),
    .hi_off_i       (hi_off_i),
    .probe_off_o    (probe_off_o),
    .outcome_o      (outcome_o),
    .placement_o    (placement_o)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("A second transaction was accepted while a step was in flight.");

  a_special_snaps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == OUTC_ZERO || outcome_o == OUTC_NOPROG)
      |-> placement_o == PLACE_SNAP)
    else $error("A degenerate bracket result was not snapped to the start.");

  a_place_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (placement_o == PLACE_END || placement_o == PLACE_ROLL ||
                     placement_o == PLACE_SNAP))
    else $error("The placement code is out of range.");

endmodule

/* bench/interpolation_seek_offset_guess_unit_tb.sv */
// Self-checking testbench for interpolation_seek_offset_guess_unit.
// Drives a directed table, random bisection sequences and random steps, and checks each
// guess against a table value or an in-bench model of the probe. Depends on isog_pkg and the RTL only.
module interpolation_seek_offset_guess_unit_tb;
  import isog_pkg::*;

  localparam int RANDOM_ITEMS = 1730;
  localparam int NUM_DIRECTED = 22;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 1000;
  localparam int DRAIN_CYCLES = 140;
  localparam longint CYCLE_LIMIT = 3000000;

  localparam logic [UNIT_W-1:0] U_MAX   = '1;
  localparam logic [OFF_W-1:0]  OFF_MAX = '1;

  typedef struct packed {
    logic              new_search;
    logic              end_known;
    logic [UNIT_W-1:0] seek_unit;
    logic [UNIT_W-1:0] lo_unit;
    logic [UNIT_W-1:0] hi_unit;
    logic [UNIT_W-1:0] unit_current;
    logic [OFF_W-1:0]  lo_off;
    logic [OFF_W-1:0]  hi_off;
  } probe_step_t;

  typedef struct packed {
    logic [OFF_W-1:0] probe_off;
    logic [1:0]       outcome;
    logic [1:0]       placement;
  } probe_guess_t;

  typedef struct packed {
    probe_step_t  step;
    logic         typed;
    probe_guess_t want;
  } dir_row_t;

  localparam probe_guess_t NO_WANT = '0;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              new_search_i;
  logic              end_known_i;
  logic [UNIT_W-1:0] seek_unit_i;
  logic [UNIT_W-1:0] lo_unit_i;
  logic [UNIT_W-1:0] hi_unit_i;
  logic [UNIT_W-1:0] unit_current_i;
  logic [OFF_W-1:0]  lo_off_i;
  logic [OFF_W-1:0]  hi_off_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [OFF_W-1:0]  probe_off_o;
  logic [1:0]        outcome_o;
  logic [1:0]        placement_o;

  probe_guess_t pending_guesses[$];
  bit           zoom_spent;
  int           mismatches;
  int           results_seen;
  int           sender_quiet_left;
  longint       cycles;

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{1'b1, 1'b1, 5, 100, 100, 7, 1000, 50000}, 1'b1, '{1000, OUTC_ZERO, PLACE_SNAP}},
    '{'{1'b0, 1'b0, 0, 200, 0, 200, OFF_MAX, 0}, 1'b1, '{OFF_MAX, OUTC_NOPROG, PLACE_SNAP}},
    '{'{1'b1, 1'b1, 0, U_MAX, U_MAX, 0, 0, OFF_MAX}, 1'b1, '{0, OUTC_ZERO, PLACE_SNAP}},
    '{'{1'b1, 1'b1, 0, 0, 1000, 0, 0, 65536}, 1'b0, NO_WANT},
    '{'{1'b0, 1'b1, 1000, 0, 1000, 0, 0, OFF_MAX}, 1'b1, '{OFF_MAX, OUTC_INTERP, PLACE_END}},
    '{'{1'b0, 1'b1, U_MAX, 0, 1000, 0, 0, OFF_MAX}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b1, 0, 500, 1000, 0, 100000, 200000}, 1'b0, NO_WANT},
    '{'{1'b0, 1'b1, 0, 500, 1000, 0, 100000, 200000}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b0, U_MAX, 0, 0, 1, 0, OFF_MAX}, 1'b1, '{OFF_MAX, OUTC_INTERP, PLACE_END}},
    '{'{1'b0, 1'b0, U_MAX, 0, 0, 1, OFF_MAX, 0}, 1'b0, NO_WANT},
    '{'{1'b0, 1'b0, 1000, 500, 0, 0, 4096, 1000000}, 1'b0, NO_WANT},
    '{'{1'b0, 1'b0, 50, 0, 0, 100, 0, 1000000}, 1'b0, NO_WANT},
    '{'{1'b0, 1'b0, 1, 0, 0, 2, 1000, 17384}, 1'b0, NO_WANT},
    '{'{1'b0, 1'b0, 1, 0, 0, 2, 1000, 17386}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b1, 1, 0, 5, 0, 0, OFF_MAX}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b1, 4, 0, 5, 0, 0, OFF_MAX}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b1, 0, 0, 5, 0, 0, OFF_MAX}, 1'b0, NO_WANT},
    '{'{1'b0, 1'b0, 10, 0, 0, 20, 0, 1048576}, 1'b0, NO_WANT},
    '{'{1'b0, 1'b1, 0, 0, 5, 0, 0, OFF_MAX}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b1, 7, 9, 9, 0, 0, 1000}, 1'b1, '{0, OUTC_ZERO, PLACE_SNAP}},
    '{'{1'b0, 1'b1, 0, 0, 5, 0, 0, OFF_MAX}, 1'b0, NO_WANT},
    '{'{1'b0, 1'b1, U_MAX, U_MAX, 0, 0, OFF_MAX, OFF_MAX}, 1'b0, NO_WANT}
  };

  interpolation_seek_offset_guess_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .new_search_i   (new_search_i),
    .end_known_i    (end_known_i),
    .seek_unit_i    (seek_unit_i),
    .lo_unit_i      (lo_unit_i),
    .hi_unit_i      (hi_unit_i),
    .unit_current_i (unit_current_i),
    .lo_off_i       (lo_off_i),
    .hi_off_i       (hi_off_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .probe_off_o    (probe_off_o),
    .outcome_o      (outcome_o),
    .placement_o    (placement_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic probe_guess_t predict_probe(input probe_step_t s);
    probe_guess_t     res;
    logic [63:0]      num;
    logic [63:0]      den;
    logic [63:0]      ratio;
    logic [63:0]      span_end;
    logic [OFF_W-1:0] width;
    logic [127:0]     mag;
    logic             num_neg;
    logic             den_neg;
    logic             r_neg;
    logic             d_neg;
    if (s.new_search) zoom_spent = 1'b0;
    span_end = 64'(s.end_known ? s.hi_unit : s.unit_current);
    num_neg = s.seek_unit < s.lo_unit;
    num = num_neg ? 64'(s.lo_unit - s.seek_unit) : 64'(s.seek_unit - s.lo_unit);
    den_neg = span_end < 64'(s.lo_unit);
    den = den_neg ? 64'(s.lo_unit) - span_end : span_end - 64'(s.lo_unit);
    if (den == 64'd0) begin
      res.probe_off = s.lo_off;
      res.outcome   = s.end_known ? OUTC_ZERO : OUTC_NOPROG;
      res.placement = PLACE_SNAP;
      return res;
    end
    ratio = (num << FRAC_W) / den;
    r_neg = (num_neg != den_neg) && (ratio != 64'd0);
    res.outcome = OUTC_INTERP;
    if (s.end_known) begin
      if (zoom_spent) begin
        zoom_spent = 1'b0;
      end else begin
        if (r_neg || ratio < 64'(R_LOW)) begin
          ratio = 64'(R_ZLOW);
          r_neg = 1'b0;
          res.outcome = OUTC_ZOOM;
        end else if (ratio > 64'(R_HIGH)) begin
          ratio = 64'(R_ZHIGH);
          res.outcome = OUTC_ZOOM;
        end
        zoom_spent = 1'b1;
      end
    end
    d_neg = s.hi_off < s.lo_off;
    width = d_neg ? s.lo_off - s.hi_off : s.hi_off - s.lo_off;
    mag = (128'(width) * 128'(ratio)) >> FRAC_W;
    if (d_neg != r_neg) begin
      res.probe_off = (mag > 128'(s.lo_off)) ? '0 : s.lo_off - OFF_W'(mag);
    end else begin
      res.probe_off = (mag + 128'(s.lo_off) > 128'(OFF_MAX)) ?
                      OFF_MAX : s.lo_off + OFF_W'(mag);
    end
    if (res.probe_off == s.hi_off) begin
      res.placement = PLACE_END;
    end else if (res.probe_off >= ROLLBACK && res.probe_off - ROLLBACK > s.lo_off) begin
      res.probe_off = res.probe_off - ROLLBACK;
      res.placement = PLACE_ROLL;
    end else begin
      res.probe_off = s.lo_off;
      res.placement = PLACE_SNAP;
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    if (roll < 97) return $urandom_range(5, 30);
    return $urandom_range(60, 200);
  endfunction

  function automatic logic [63:0] rand_word(input int w);
    logic [63:0] mask;
    logic [63:0] v;
    mask = (64'd1 << w) - 64'd1;
    case ($urandom_range(0, 4))
      0, 1: v = {$urandom, $urandom};
      2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      3: v = 64'($urandom_range(0, 40));
      default: v = mask - 64'($urandom_range(0, 40));
    endcase
    return v & mask;
  endfunction

  function automatic logic [63:0] pick_between(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] lo;
    logic [63:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return lo + ({$urandom, $urandom} % (hi - lo + 64'd1));
  endfunction

  task automatic send_probe(input probe_step_t s, input logic typed, input probe_guess_t want);
    probe_guess_t model;
    int           gap;
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    new_search_i   <= s.new_search;
    end_known_i    <= s.end_known;
    seek_unit_i    <= s.seek_unit;
    lo_unit_i      <= s.lo_unit;
    hi_unit_i      <= s.hi_unit;
    unit_current_i <= s.unit_current;
    lo_off_i       <= s.lo_off;
    hi_off_i       <= s.hi_off;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model = predict_probe(s);
    pending_guesses.push_back(typed ? want : model);
    if (sender_quiet_left > 0) begin
      gap = 0;
      sender_quiet_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 99) == 0) sender_quiet_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic run_search_seq(input int steps);
    probe_step_t s;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] oa;
    logic [63:0] ob;
    logic [63:0] tmp;
    ua = rand_word(UNIT_W);
    ub = rand_word(UNIT_W);
    if (ua > ub) begin
      tmp = ua;
      ua = ub;
      ub = tmp;
    end
    oa = rand_word(OFF_W);
    ob = rand_word(OFF_W);
    if (oa > ob && $urandom_range(0, 7) != 0) begin
      tmp = oa;
      oa = ob;
      ob = tmp;
    end
    for (int i = 0; i < steps; i++) begin
      s.new_search   = (i == 0) || ($urandom_range(0, 19) == 0);
      s.end_known    = $urandom_range(0, 5) != 0;
      s.lo_unit      = UNIT_W'(ua);
      s.hi_unit      = UNIT_W'(ub);
      s.seek_unit    = UNIT_W'(($urandom_range(0, 7) == 0) ? rand_word(UNIT_W)
                                                          : pick_between(ua, ub));
      s.unit_current = UNIT_W'(pick_between(ua, ub));
      if ($urandom_range(0, 15) == 0) begin
        s.hi_unit      = UNIT_W'(ua);
        s.unit_current = UNIT_W'(ua);
      end
      s.lo_off = OFF_W'(oa);
      s.hi_off = OFF_W'(ob);
      send_probe(s, 1'b0, NO_WANT);
      if (s.unit_current < s.seek_unit) begin
        ua = 64'(s.unit_current);
        oa = pick_between(oa, ob);
      end else begin
        ub = 64'(s.unit_current);
        ob = pick_between(oa, ob);
      end
    end
  endtask

  task automatic send_noise();
    probe_step_t s;
    s.new_search   = 1'($urandom_range(0, 1));
    s.end_known    = 1'($urandom_range(0, 1));
    s.seek_unit    = UNIT_W'(rand_word(UNIT_W));
    s.lo_unit      = UNIT_W'(rand_word(UNIT_W));
    s.hi_unit      = UNIT_W'(rand_word(UNIT_W));
    s.unit_current = UNIT_W'(rand_word(UNIT_W));
    s.lo_off       = OFF_W'(rand_word(OFF_W));
    s.hi_off       = OFF_W'(rand_word(OFF_W));
    send_probe(s, 1'b0, NO_WANT);
  endtask

  always @(posedge clk_i) begin : check_result
    probe_guess_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_guesses.size() == 0) begin
        $display("%0t: unexpected result transaction, guess %h outcome %0d placement %0d",
                 $time, probe_off_o, outcome_o, placement_o);
        mismatches++;
      end else begin
        want = pending_guesses.pop_front();
        if (probe_off_o !== want.probe_off) begin
          $display("%0t: probe_off expected %h actual %h",
                   $time, want.probe_off, probe_off_o);
          mismatches++;
        end
        if (outcome_o !== want.outcome) begin
          $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, outcome_o);
          mismatches++;
        end
        if (placement_o !== want.placement) begin
          $display("%0t: placement expected %0d actual %0d", $time, want.placement, placement_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : drive_out_ready
    int idle_left;
    int quiet_left;
    bit held;
    idle_left = 0;
    quiet_left = 0;
    held = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (idle_left > 0) begin
        out_ready_i <= 1'b0;
        idle_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (quiet_left > 0) begin
          quiet_left--;
        end else if ($urandom_range(0, 299) == 0) begin
          quiet_left = $urandom_range(200, 800);
        end else if ($urandom_range(0, 19) == 0) begin
          idle_left = pick_gap();
        end
      end
    end
  end

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : run_stimulus
    int  sent;
    int  steps;
    bit  paused;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    new_search_i = 1'b0;
    end_known_i = 1'b0;
    seek_unit_i = '0;
    lo_unit_i = '0;
    hi_unit_i = '0;
    unit_current_i = '0;
    lo_off_i = '0;
    hi_off_i = '0;
    zoom_spent = 1'b0;
    mismatches = 0;
    results_seen = 0;
    sender_quiet_left = 0;
    sent = 0;
    paused = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_probe(directed_rows[i].step, directed_rows[i].typed, directed_rows[i].want);
    end

    while (sent < RANDOM_ITEMS) begin
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (pending_guesses.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 99) < 85) begin
        steps = $urandom_range(1, 8);
        run_search_seq(steps);
        sent += steps;
      end else begin
        send_noise();
        sent++;
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_guesses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/isog_pkg.sv
hdl/isog_ctrl.sv
hdl/isog_dp.sv
hdl/interpolation_seek_offset_guess_unit.sv
bench/interpolation_seek_offset_guess_unit_tb.sv
